@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define BAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("splitter check failed");

// Next-cycle implication, switched off while reset is held.
`define BAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("splitter check failed");

// Next-cycle implication that is also checked during reset.
`define BAS_ASSERT_NXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("splitter check failed");

`endif

@@ hw/rtl/bas_pkg.sv @@
// Package with the types, codes and character constants of the argument splitter.
package bas_pkg;

    localparam int BAS_STACK_DEPTH = 16;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Expected closer held on the nesting stack.
    typedef enum logic [1:0] {
        CL_PAREN  = 2'd0,
        CL_SQUARE = 2'd1,
        CL_CURLY  = 2'd2,
        CL_QUOTE  = 2'd3
    } t_closer;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNMATCHED = 2'd1,
        ERR_UNCLOSED  = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } t_err;

    // A classified item as it travels from the front end to the back end.
    // A double quote is both an opener and a closer of the quote scope.
    typedef struct packed {
        logic       is_end;
        logic [7:0] chr;
        logic       is_comma;
        logic       is_space;
        logic       is_open;
        logic       is_close;
        t_closer    code;
    } t_item;

endpackage

@@ hw/rtl/bas_ifs.sv @@
// Valid/ready channel interfaces for the input and result items of the splitter.
interface bas_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] character;

    modport source (output valid, output kind, output character, input ready);
    modport sink   (input valid, input kind, input character, output ready);
endinterface

interface bas_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       append;
    logic       token_end;
    logic       list_done;
    logic [1:0] error;

    modport source (output valid, output out_char, output append, output token_end,
                    output list_done, output error, input ready);
    modport sink   (input valid, input out_char, input append, input token_end,
                    input list_done, input error, output ready);
endinterface

@@ hw/rtl/bas_front.sv @@
// Front end: accepts input items and classifies each byte for the back end.
module bas_front
    import bas_pkg::*;
(
    bas_in_if.sink  i_in,
    output logic    o_valid,
    output t_item   o_item,
    input  logic    i_ready
);

    assign i_in.ready = i_ready;
    assign o_valid    = i_in.valid;

    always_comb begin
        o_item          = '0;
        o_item.is_end   = i_in.kind;
        o_item.chr      = i_in.character;
        o_item.code     = CL_PAREN;
        unique case (i_in.character)
            CH_COMMA:  o_item.is_comma = 1'b1;
            CH_LPAREN: begin
                o_item.is_open = 1'b1;
                o_item.code    = CL_PAREN;
            end
            CH_RPAREN: begin
                o_item.is_close = 1'b1;
                o_item.code     = CL_PAREN;
            end
            CH_LSQ: begin
                o_item.is_open = 1'b1;
                o_item.code    = CL_SQUARE;
            end
            CH_RSQ: begin
                o_item.is_close = 1'b1;
                o_item.code     = CL_SQUARE;
            end
            CH_LCURLY: begin
                o_item.is_open = 1'b1;
                o_item.code    = CL_CURLY;
            end
            CH_RCURLY: begin
                o_item.is_close = 1'b1;
                o_item.code     = CL_CURLY;
            end
            CH_QUOTE: begin
                o_item.is_open  = 1'b1;
                o_item.is_close = 1'b1;
                o_item.code     = CL_QUOTE;
            end
            CH_SPACE, CH_TAB, CH_LF, CH_CR: o_item.is_space = 1'b1;
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/bas_queue.sv @@
// Two-entry queue that decouples the front end from the back end.
module bas_queue
    import bas_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_ready
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ hw/rtl/bas_back.sv @@
// Back end: nesting stack, token tracking and the registered result stage.
module bas_back
    import bas_pkg::*;
#(
    parameter int STACK_DEPTH = BAS_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_ready,
    bas_out_if.source   o_out
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Stack of expected closers; the top is read back through a registered port.
    t_closer            r_stack [STACK_DEPTH];
    t_closer            r_rd_data;
    t_closer            r_push_code;
    logic               r_bypass;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_has_text;
    logic               n_has_text;
    logic               r_started;
    logic               n_started;
    t_err               r_fault;
    t_err               n_fault;

    logic               r_valid;
    logic [7:0]         r_char;
    logic               r_append;
    logic               r_tend;
    logic               r_done;
    t_err               r_err;

    logic [7:0]         res_char;
    logic               res_append;
    logic               res_tend;
    logic               res_done;
    t_err               res_err;

    logic               take;
    logic               empty;
    logic               full;
    logic               do_push;
    t_closer            top;
    logic [CNT_W-1:0]   rd_cnt;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;

    assign take    = i_valid && (!r_valid || o_out.ready);
    assign o_ready = !r_valid || o_out.ready;
    assign empty   = (r_count == '0);
    assign full    = (r_count == CNT_W'(STACK_DEPTH));
    assign top     = r_bypass ? r_push_code : r_rd_data;
    assign rd_cnt  = n_count - CNT_W'(1);
    assign rd_addr = rd_cnt[IDX_W-1:0];
    assign wr_addr = r_count[IDX_W-1:0];

    always_comb begin
        n_count    = r_count;
        n_has_text = r_has_text;
        n_started  = r_started;
        n_fault    = r_fault;
        do_push    = 1'b0;
        res_char   = i_item.is_end ? 8'd0 : i_item.chr;
        res_append = 1'b0;
        res_tend   = 1'b0;
        res_done   = 1'b0;
        res_err    = ERR_NONE;
        if (take) begin
            priority if (i_item.is_end) begin
                res_done = 1'b1;
                priority if (r_fault != ERR_NONE) begin
                    res_err = r_fault;
                end else if (!empty) begin
                    res_err = ERR_UNCLOSED;
                end else begin
                    res_tend = r_started || r_has_text;
                end
                n_count    = '0;
                n_has_text = 1'b0;
                n_started  = 1'b0;
                n_fault    = ERR_NONE;
            end else if (r_fault != ERR_NONE) begin
                res_err = r_fault;
            end else begin
                priority if (empty && i_item.is_comma) begin
                    res_tend   = 1'b1;
                    n_has_text = 1'b0;
                    n_started  = 1'b1;
                end else if (!empty && i_item.is_close && i_item.code == top) begin
                    n_count    = r_count - CNT_W'(1);
                    res_append = 1'b1;
                end else if (empty || top != CL_QUOTE) begin
                    priority if (i_item.is_open) begin
                        if (full) begin
                            n_fault = ERR_OVERFLOW;
                        end else begin
                            do_push    = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                            res_append = 1'b1;
                        end
                    end else if (i_item.is_space) begin
                        res_append = 1'b0;
                    end else if (i_item.is_close) begin
                        n_fault = ERR_UNMATCHED;
                    end else begin
                        res_append = 1'b1;
                    end
                    res_err = n_fault;
                end else begin
                    // Inside a quote every byte is kept; the closing quote is taken by the branch above.
                    res_append = 1'b1;
                end
                if (res_append) begin
                    n_has_text = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_has_text <= 1'b0;
            r_started  <= 1'b0;
            r_fault    <= ERR_NONE;
            r_valid    <= 1'b0;
            r_bypass   <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_has_text <= n_has_text;
            r_started  <= n_started;
            r_fault    <= n_fault;
            r_valid    <= take || (r_valid && !o_out.ready);
            r_bypass   <= do_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_stack[wr_addr] <= i_item.code;
        end
        r_rd_data   <= r_stack[rd_addr];
        r_push_code <= i_item.code;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char   <= res_char;
            r_append <= res_append;
            r_tend   <= res_tend;
            r_done   <= res_done;
            r_err    <= res_err;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_char  = r_char;
    assign o_out.append    = r_append;
    assign o_out.token_end = r_tend;
    assign o_out.list_done = r_done;
    assign o_out.error     = r_err;

endmodule

@@ hw/rtl/bracket_aware_argument_splitter_unit.sv @@
// Top level of the bracket-aware argument splitter.
//
// The block splits a byte string into comma-separated tokens. Each input item on
// i_in carries one byte (kind 0) or the end-of-string marker (kind 1). Each input
// item gives exactly one result item on o_out, which says whether the byte joins
// the current token, whether a token ended, whether the list is done and which
// error, if any, the string has met. Commas inside brackets, braces, parentheses
// or double quotes do not split, and whitespace outside quotes is dropped.
// Both channels use valid/ready; an item moves on a clock edge with both high.
// An accepted item is classified in the front end and written to a two-entry
// queue; the back end takes it from the queue and registers its result. One item
// per cycle is sustained while the receiver is ready: the nesting stack is only
// ever touched at its top, which is held in a register fed by the stack memory's
// single read port with a bypass for a push in the previous cycle.
// Reset empties the queue, the output stage and the stack; no clearing pass is
// needed, so the block takes items in the first cycle after reset. When the
// receiver stalls, the result is held in the output register, the queue fills,
// and i_in.ready falls once both queue entries are occupied.
module bracket_aware_argument_splitter_unit
    import bas_pkg::*;
#(
    parameter int STACK_DEPTH = BAS_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bas_in_if.sink      i_in,
    bas_out_if.source   o_out
);

    logic  front_valid;
    t_item front_item;
    logic  front_ready;
    logic  queue_valid;
    t_item queue_item;
    logic  back_ready;

    // Classifies each byte so that the back end compares class bits only.
    bas_front u_front (
        .i_in    (i_in),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (front_ready)
    );

    // Lets the front end keep accepting while a result waits to be taken.
    bas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_ready (front_ready),
        .o_valid (queue_valid),
        .o_item  (queue_item),
        .i_ready (back_ready)
    );

    // Carries out the nesting rules and registers the result item.
    bas_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_ready (back_ready),
        .o_out   (o_out)
    );

endmodule

@@ hw/rtl/bas_checker.sv @@
// Port-level assertions for the splitter and the bind that attaches them.
`include "assert_macros.svh"

module bas_checker
    import bas_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_append,
    input logic       i_token_end,
    input logic       i_list_done,
    input logic [1:0] i_error
);

    logic [12:0] out_payload;
    logic        stalled;
    logic        end_quiet;
    logic        err_seen;
    logic        err_quiet;

    assign out_payload = {i_out_char, i_append, i_token_end, i_list_done, i_error};
    assign stalled     = i_out_valid && !i_out_ready;
    assign end_quiet   = (i_out_char == 8'd0) && !i_append;
    assign err_seen    = (i_error != ERR_NONE);
    assign err_quiet   = !i_append && !i_token_end;

    // A stalled result must keep its payload.
    `BAS_ASSERT_NXT(a_hold, i_clk, i_rst_n, stalled, i_out_valid && $stable(out_payload))

    // Reset empties the output stage.
    `BAS_ASSERT_NXT_ANY(a_reset_clears, i_clk, !i_rst_n, !i_out_valid)

    // An end-of-string result carries no byte and never appends.
    `BAS_ASSERT_IMP(a_end_item, i_clk, i_rst_n, i_out_valid && i_list_done, end_quiet)

    // An erroneous result never appends and never ends a token.
    `BAS_ASSERT_IMP(a_err_quiet, i_clk, i_rst_n, i_out_valid && err_seen, err_quiet)

endmodule

bind bracket_aware_argument_splitter_unit bas_checker u_bas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_append    (o_out.append),
    .i_token_end (o_out.token_end),
    .i_list_done (o_out.list_done),
    .i_error     (o_out.error)
);

@@ verif/bracket_aware_argument_splitter_unit_tb.sv @@
// Self-checking testbench for the bracket-aware argument splitter, with a random driver and monitor.
`timescale 1ns / 1ps

module bracket_aware_argument_splitter_unit_tb;
    import bas_pkg::*;

    // The run is stopped here if the block hangs.
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 750;
    localparam int IDLE_PERCENT = 32;
    // Items (and results) within this window are moved with no idling at all.
    localparam int CALM_FROM = 250;
    localparam int CALM_TO = 400;
    localparam int MAX_REPORTS = 10;

    // Shapes of generated strings.
    localparam int SHAPE_CLEAN = 0;
    localparam int SHAPE_UNCLOSED = 1;
    localparam int SHAPE_STRAY = 2;
    localparam int SHAPE_DEEP = 3;
    localparam int SHAPE_NOISE = 4;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef struct {
        logic       kind;
        logic [7:0] character;
    } t_char_item;

    typedef struct {
        logic [7:0] out_char;
        logic       append;
        logic       token_end;
        logic       list_done;
        t_err       error;
    } t_split_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bas_in_if  in_bus ();
    bas_out_if out_bus ();

    bracket_aware_argument_splitter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #10 i_clk = ~i_clk;

    // Items still to be offered, and the results that accepted items must give.
    t_char_item    pending_chars[$];
    t_split_result expected_splits[$];

    // Our own copy of the splitter state, updated as each item is accepted.
    t_closer     nest_stack[BAS_STACK_DEPTH];
    int unsigned nest_depth = 0;
    bit          token_open = 1'b0;
    bit          list_split = 1'b0;
    t_err        held_fault = ERR_NONE;

    int unsigned cycle_count = 0;
    int unsigned sent_count = 0;
    int unsigned checked_count = 0;
    int unsigned mismatches = 0;
    bit          in_taken = 1'b0;
    t_split_result want;

    // Works out the result of one item and moves the state on, exactly as the
    // block should. The quote scope is special: inside it only a double quote
    // means anything, and it closes the scope.
    function automatic t_split_result split_byte(logic kind, logic [7:0] ch);
        t_split_result r;
        bit            at_top;
        bit            is_open;
        t_closer       top;
        t_closer       code;
        logic [7:0]    top_char;
        r = '{out_char: ch, append: 1'b0, token_end: 1'b0, list_done: 1'b0, error: ERR_NONE};
        code = CL_PAREN;
        if (kind == KIND_END) begin
            r.out_char = 8'h00;
            r.list_done = 1'b1;
            if (held_fault != ERR_NONE) begin
                r.error = held_fault;
            end else if (nest_depth != 0) begin
                r.error = ERR_UNCLOSED;
            end else begin
                // An empty string, or one of whitespace alone, ends no token.
                r.token_end = list_split || token_open;
            end
            nest_depth = 0;
            token_open = 1'b0;
            list_split = 1'b0;
            held_fault = ERR_NONE;
        end else if (held_fault != ERR_NONE) begin
            // The rest of a faulty string is ignored, but the code is shown.
            r.error = held_fault;
        end else begin
            at_top = (nest_depth == 0);
            top = at_top ? CL_PAREN : nest_stack[nest_depth - 1];
            case (top)
                CL_PAREN: begin
                    top_char = CH_RPAREN;
                end
                CL_SQUARE: begin
                    top_char = CH_RSQ;
                end
                CL_CURLY: begin
                    top_char = CH_RCURLY;
                end
                default: begin
                    top_char = CH_QUOTE;
                end
            endcase
            if (at_top && ch == CH_COMMA) begin
                r.token_end = 1'b1;
                token_open = 1'b0;
                list_split = 1'b1;
            end else if (!at_top && ch == top_char) begin
                nest_depth--;
                r.append = 1'b1;
            end else if (at_top || top != CL_QUOTE) begin
                is_open = 1'b1;
                case (ch)
                    CH_LPAREN: begin
                        code = CL_PAREN;
                    end
                    CH_LSQ: begin
                        code = CL_SQUARE;
                    end
                    CH_LCURLY: begin
                        code = CL_CURLY;
                    end
                    CH_QUOTE: begin
                        code = CL_QUOTE;
                    end
                    default: begin
                        is_open = 1'b0;
                    end
                endcase
                if (is_open) begin
                    // An opener with the stack full is a nesting overflow.
                    if (nest_depth >= BAS_STACK_DEPTH) begin
                        held_fault = ERR_OVERFLOW;
                    end else begin
                        nest_stack[nest_depth] = code;
                        nest_depth++;
                        r.append = 1'b1;
                    end
                end else if (ch inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
                    r.append = 1'b0;
                end else if (ch inside {CH_RPAREN, CH_RSQ, CH_RCURLY}) begin
                    held_fault = ERR_UNMATCHED;
                end else begin
                    r.append = 1'b1;
                end
                r.error = held_fault;
            end else begin
                r.append = 1'b1;
            end
            if (r.append) begin
                token_open = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic push_char(logic kind, logic [7:0] ch);
        t_char_item entry;
        entry = '{kind: kind, character: ch};
        pending_chars.insert(pending_chars.size(), entry);
    endtask

    // A byte with no meaning to the splitter outside quotes.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b inside {CH_COMMA, CH_LPAREN, CH_RPAREN, CH_LSQ, CH_RSQ, CH_LCURLY,
                             CH_RCURLY, CH_QUOTE, CH_SPACE, CH_TAB, CH_LF, CH_CR});
        return b;
    endfunction

    // Any of the bytes that the splitter treats specially.
    function automatic logic [7:0] punct_byte();
        case ($urandom_range(0, 11))
            0: return CH_COMMA;
            1: return CH_LPAREN;
            2: return CH_RPAREN;
            3: return CH_LSQ;
            4: return CH_RSQ;
            5: return CH_LCURLY;
            6: return CH_RCURLY;
            7: return CH_QUOTE;
            8: return CH_SPACE;
            9: return CH_TAB;
            10: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Builds one string, closed by the end marker. Clean strings keep their
    // scopes balanced so that they reach the deeper states; the other shapes
    // leave a scope open, put in a stray closer, nest too deeply or are noise.
    task automatic gen_string(int shape);
        logic [7:0] closers[$];
        logic [7:0] c;
        int         n;
        int         pick;
        bit         in_quote;
        n = int'($urandom_range(0, 20));
        if (shape == SHAPE_NOISE) begin
            for (int i = 0; i < n; i++) begin
                push_char(KIND_CHAR, $urandom_range(0, 1) ? plain_byte() : punct_byte());
            end
        end else if (shape == SHAPE_DEEP) begin
            // One short of full, just full, or one or two beyond, which overflows.
            n = int'($urandom_range(BAS_STACK_DEPTH - 1, BAS_STACK_DEPTH + 2));
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 2))
                    0: begin
                        push_char(KIND_CHAR, CH_LPAREN);
                        closers.insert(closers.size(), CH_RPAREN);
                    end
                    1: begin
                        push_char(KIND_CHAR, CH_LSQ);
                        closers.insert(closers.size(), CH_RSQ);
                    end
                    default: begin
                        push_char(KIND_CHAR, CH_LCURLY);
                        closers.insert(closers.size(), CH_RCURLY);
                    end
                endcase
            end
            push_char(KIND_CHAR, plain_byte());
        end else begin
            for (int i = 0; i < n; i++) begin
                in_quote = closers.size() > 0 && closers[$] == CH_QUOTE;
                pick = int'($urandom_range(0, 99));
                if (in_quote) begin
                    if (pick < 20) begin
                        c = closers.pop_back();
                    end else begin
                        do begin
                            c = 8'($urandom_range(0, 255));
                        end while (c == CH_QUOTE);
                    end
                end else if (pick < 14 && closers.size() < 5) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            c = CH_LPAREN;
                            closers.insert(closers.size(), CH_RPAREN);
                        end
                        1: begin
                            c = CH_LSQ;
                            closers.insert(closers.size(), CH_RSQ);
                        end
                        2: begin
                            c = CH_LCURLY;
                            closers.insert(closers.size(), CH_RCURLY);
                        end
                        default: begin
                            c = CH_QUOTE;
                            closers.insert(closers.size(), CH_QUOTE);
                        end
                    endcase
                end else if (pick < 28 && closers.size() > 0) begin
                    c = closers.pop_back();
                end else if (pick < 40) begin
                    c = CH_COMMA;
                end else if (pick < 48) begin
                    case ($urandom_range(0, 3))
                        0: c = CH_SPACE;
                        1: c = CH_TAB;
                        2: c = CH_LF;
                        default: c = CH_CR;
                    endcase
                end else begin
                    c = plain_byte();
                end
                push_char(KIND_CHAR, c);
            end
            if (shape == SHAPE_STRAY) begin
                case ($urandom_range(0, 2))
                    0: push_char(KIND_CHAR, CH_RPAREN);
                    1: push_char(KIND_CHAR, CH_RSQ);
                    default: push_char(KIND_CHAR, CH_RCURLY);
                endcase
                repeat ($urandom_range(0, 3)) push_char(KIND_CHAR, plain_byte());
            end
        end
        if (shape != SHAPE_UNCLOSED) begin
            while (closers.size() > 0) begin
                push_char(KIND_CHAR, closers.pop_back());
            end
        end else if (closers.size() == 0) begin
            push_char(KIND_CHAR, CH_LSQ);
        end
        // The byte of an end marker is ignored, so it is random.
        push_char(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    // Acceptance of input items: each one accepted is run through our copy of
    // the splitter, and its result joins the queue of expectations.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            expected_splits.insert(expected_splits.size(),
                                   split_byte(in_bus.kind, in_bus.character));
            void'(pending_chars.pop_front());
            sent_count++;
            in_taken = 1'b1;
        end
    end

    // Driver: a new item, or a gap, is put on the bus at the falling edge once
    // the previous item has gone. An offered item is held until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            in_taken = 1'b0;
            if (pending_chars.size() != 0 &&
                ((sent_count >= CALM_FROM && sent_count < CALM_TO) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                in_bus.valid     <= 1'b1;
                in_bus.kind      <= pending_chars[0].kind;
                in_bus.character <= pending_chars[0].character;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: every result taken is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            checked_count++;
            if (expected_splits.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d arrived with nothing expected: char %h", checked_count,
                             out_bus.out_char);
                end
            end else begin
                want = expected_splits.pop_front();
                if (out_bus.out_char !== want.out_char || out_bus.append !== want.append ||
                    out_bus.token_end !== want.token_end ||
                    out_bus.list_done !== want.list_done || out_bus.error !== want.error) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: expected char %h app %b end %b done %b err %0d",
                                 checked_count, want.out_char, want.append, want.token_end,
                                 want.list_done, want.error);
                        $display("result %0d:      got char %h app %b end %b done %b err %0d",
                                 checked_count, out_bus.out_char, out_bus.append,
                                 out_bus.token_end, out_bus.list_done, out_bus.error);
                    end
                end
            end
        end
    end

    // The receiver stalls at random as well, except within the calm window.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= (checked_count >= CALM_FROM && checked_count < CALM_TO) ||
                             $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    initial begin
        int shape_pick;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.kind = KIND_CHAR;
        in_bus.character = 8'h00;
        out_bus.ready = 1'b0;

        // Directed strings first. An empty string gives no token.
        push_char(KIND_END, 8'hFF);
        // Extreme bytes, a top-level comma, then whitespace only: the comma
        // means that the end still completes a (empty) token.
        push_char(KIND_CHAR, 8'h00);
        push_char(KIND_CHAR, 8'hFF);
        push_char(KIND_CHAR, CH_COMMA);
        push_char(KIND_CHAR, CH_TAB);
        push_char(KIND_CHAR, CH_LF);
        push_char(KIND_CHAR, CH_CR);
        push_char(KIND_CHAR, CH_SPACE);
        push_char(KIND_END, 8'h00);
        // A nested comma does not split; a closer of the wrong kind is stray.
        push_char(KIND_CHAR, CH_LPAREN);
        push_char(KIND_CHAR, CH_LSQ);
        push_char(KIND_CHAR, CH_COMMA);
        push_char(KIND_CHAR, CH_RSQ);
        push_char(KIND_CHAR, CH_LCURLY);
        push_char(KIND_CHAR, CH_RPAREN);
        push_char(KIND_END, 8'h5A);
        // Inside quotes commas and closers are plain text.
        push_char(KIND_CHAR, CH_QUOTE);
        push_char(KIND_CHAR, CH_COMMA);
        push_char(KIND_CHAR, CH_RSQ);
        push_char(KIND_CHAR, CH_QUOTE);
        push_char(KIND_END, 8'hA5);
        // A quote opened inside braces, left open at the end.
        push_char(KIND_CHAR, CH_LCURLY);
        push_char(KIND_CHAR, CH_QUOTE);
        push_char(KIND_END, 8'h01);

        // Random strings, mostly well formed.
        while (pending_chars.size() < ITEM_TARGET) begin
            shape_pick = int'($urandom_range(0, 99));
            if (shape_pick < 65) begin
                gen_string(SHAPE_CLEAN);
            end else if (shape_pick < 73) begin
                gen_string(SHAPE_UNCLOSED);
            end else if (shape_pick < 81) begin
                gen_string(SHAPE_STRAY);
            end else if (shape_pick < 88) begin
                gen_string(SHAPE_DEEP);
            end else begin
                gen_string(SHAPE_NOISE);
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every item to go in and every result to come out, then a
        // little longer to catch any result that should not be there.
        while (pending_chars.size() != 0 || expected_splits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && expected_splits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bas_pkg.sv
hw/rtl/bas_ifs.sv
hw/rtl/bas_front.sv
hw/rtl/bas_queue.sv
hw/rtl/bas_back.sv
hw/rtl/bracket_aware_argument_splitter_unit.sv
hw/rtl/bas_checker.sv
verif/bracket_aware_argument_splitter_unit_tb.sv
